// ===== rtl/core/pcg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pcg_pkg;
    localparam logic [63:0] PCG_MULT  = 64'd6364136223846793005;
    localparam logic [63:0] MIX_GOLD  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_C1    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2    = 64'h94d049bb133111eb;
    localparam int          PROB_BITS = 24;

    localparam logic [2:0] CMD_WORD32 = 3'd0;
    localparam logic [2:0] CMD_WORD64 = 3'd1;
    localparam logic [2:0] CMD_BELOW  = 3'd2;
    localparam logic [2:0] CMD_RANGE  = 3'd3;
    localparam logic [2:0] CMD_FRAC   = 3'd4;
    localparam logic [2:0] CMD_CHANCE = 3'd5;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_SEED_INIT = 4'd1;
    localparam logic [3:0] OP_DRAW      = 4'd2;
    localparam logic [3:0] OP_STATE_UPD = 4'd3;
    localparam logic [3:0] OP_MIX_ADD   = 4'd4;
    localparam logic [3:0] OP_MUL_X1    = 4'd5;
    localparam logic [3:0] OP_MUL_X2    = 4'd6;
    localparam logic [3:0] OP_X_PROD    = 4'd7;
    localparam logic [3:0] OP_ADD_MIX   = 4'd8;
    localparam logic [3:0] OP_LOAD      = 4'd9;
    localparam logic [3:0] OP_DIV_THR   = 4'd10;
    localparam logic [3:0] OP_DIV_WORD  = 4'd11;
    localparam logic [3:0] OP_THR_SAVE  = 4'd12;

    localparam logic [3:0] RES_ZERO   = 4'd0;
    localparam logic [3:0] RES_ONE    = 4'd1;
    localparam logic [3:0] RES_BASE   = 4'd2;
    localparam logic [3:0] RES_WORD   = 4'd3;
    localparam logic [3:0] RES_HI     = 4'd4;
    localparam logic [3:0] RES_LO     = 4'd5;
    localparam logic [3:0] RES_FRAC   = 4'd6;
    localparam logic [3:0] RES_CHANCE = 4'd7;
    localparam logic [3:0] RES_REM    = 4'd8;

    typedef struct packed {
        logic [3:0] op;
        logic       res_we;
        logic [3:0] res_sel;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic       span_zero;
        logic       range_empty;
        logic       prob_zero;
        logic       prob_full;
        logic       mul_done;
        logic       div_done;
        logic       word_ge_thr;
        logic       out_free;
        logic       cfg_known;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/pcg_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pcg_datapath import pcg_pkg::*; #(
    parameter int FRACTION_BITS = 24
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dp_cmd_t       cmd,
    output dp_stat_t           stat,
    input  wire logic [127:0]  s_tdata,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_ready,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [63:0]   cfg_data,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata
);
    logic [63:0] seed_reg, state_reg, inc_reg, x_reg;
    logic [62:0] seq_reg;
    logic [2:0]  command_reg;
    logic [31:0] lo_reg, hi_reg, span_reg, base_reg, word_reg, thr_reg;
    logic [24:0] prob_reg;
    logic [63:0] res_reg, out_reg;
    logic        out_valid_reg;

    logic [63:0] mul_a_reg, mul_b_reg, prod_reg, acc_reg;
    logic [1:0]  mul_cnt_reg;
    logic        mul_busy_reg;
    logic [31:0] ma, mb;

    logic [31:0] div_n_reg, div_r_reg;
    logic [4:0]  div_cnt_reg;
    logic        div_busy_reg;
    logic [32:0] div_trial;

    logic [31:0] xs, word_next;
    logic [4:0]  rot;
    logic [63:0] res_next;

    assign xs = 32'((((state_reg >> 18) ^ state_reg) >> 27));
    assign rot = state_reg[63:59];
    assign word_next = 32'({xs, xs} >> rot);

    always_comb begin
        case (mul_cnt_reg)
            2'd1:    begin ma = mul_a_reg[31:0];  mb = mul_b_reg[63:32]; end
            2'd2:    begin ma = mul_a_reg[63:32]; mb = mul_b_reg[31:0];  end
            default: begin ma = mul_a_reg[31:0];  mb = mul_b_reg[31:0];  end
        endcase
    end

    assign div_trial = {div_r_reg, div_n_reg[31]};

    always_comb begin
        case (cmd.res_sel)
            RES_ONE:    res_next = 64'd1;
            RES_BASE:   res_next = {32'd0, base_reg};
            RES_WORD:   res_next = {32'd0, word_reg};
            RES_HI:     res_next = {word_reg, 32'd0};
            RES_LO:     res_next = {res_reg[63:32], word_reg};
            RES_FRAC:   res_next = {32'd0, word_reg >> (32 - FRACTION_BITS)};
            RES_CHANCE: res_next = {63'd0, ({1'b0, word_reg[31:32-PROB_BITS]} < prob_reg)};
            RES_REM:    res_next = {32'd0, base_reg + div_r_reg};
            default:    res_next = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            seq_reg       <= '0;
            mul_busy_reg  <= 1'b0;
            mul_cnt_reg   <= '0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == 8'd0) seed_reg <= cfg_data;
                if (cfg_index == 8'd1) seq_reg <= cfg_data[62:0];
            end
            if (mul_busy_reg) begin
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd3) mul_busy_reg <= 1'b0;
            end
            if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31) div_busy_reg <= 1'b0;
            end
            if (cmd.op == OP_DRAW || cmd.op == OP_MUL_X1 || cmd.op == OP_MUL_X2) begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= '0;
            end
            if (cmd.op == OP_DIV_THR || cmd.op == OP_DIV_WORD) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            if (cmd.out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(ma) * 64'(mb);
        case (mul_cnt_reg)
            2'd1:    acc_reg <= prod_reg;
            2'd2,
            2'd3:    acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            default: acc_reg <= acc_reg;
        endcase
        if (div_busy_reg) begin
            div_n_reg <= {div_n_reg[30:0], 1'b0};
            div_r_reg <= (div_trial >= {1'b0, span_reg}) ?
                         32'(div_trial - {1'b0, span_reg}) : div_trial[31:0];
        end
        if (cmd.res_we) res_reg <= res_next;
        if (cmd.out_load) out_reg <= res_reg;
        case (cmd.op)
            OP_SEED_INIT: begin
                state_reg <= '0;
                inc_reg   <= {seq_reg, 1'b1};
                x_reg     <= seed_reg;
            end
            OP_DRAW: begin
                word_reg  <= word_next;
                mul_a_reg <= state_reg;
                mul_b_reg <= PCG_MULT;
            end
            OP_STATE_UPD: state_reg <= acc_reg + inc_reg;
            OP_MIX_ADD:   x_reg <= x_reg + MIX_GOLD;
            OP_MUL_X1: begin
                mul_a_reg <= x_reg ^ (x_reg >> 30);
                mul_b_reg <= MIX_C1;
            end
            OP_MUL_X2: begin
                mul_a_reg <= x_reg ^ (x_reg >> 27);
                mul_b_reg <= MIX_C2;
            end
            OP_X_PROD:    x_reg <= acc_reg;
            OP_ADD_MIX:   state_reg <= state_reg + (x_reg ^ (x_reg >> 31));
            OP_LOAD: begin
                command_reg <= s_tdata[2:0];
                lo_reg      <= s_tdata[66:35];
                hi_reg      <= s_tdata[98:67];
                prob_reg    <= s_tdata[123:99];
                span_reg    <= (s_tdata[2:0] == CMD_RANGE) ?
                               s_tdata[98:67] - s_tdata[66:35] + 32'd1 : s_tdata[34:3];
                base_reg    <= (s_tdata[2:0] == CMD_RANGE) ? s_tdata[66:35] : 32'd0;
            end
            OP_DIV_THR: begin
                div_n_reg <= 32'd0 - span_reg;
                div_r_reg <= '0;
            end
            OP_DIV_WORD: begin
                div_n_reg <= word_reg;
                div_r_reg <= '0;
            end
            OP_THR_SAVE:  thr_reg <= div_r_reg;
            default: ;
        endcase
    end

    always_comb begin
        stat.command     = command_reg;
        stat.span_zero   = (span_reg == 32'd0);
        stat.range_empty = ($signed(hi_reg) <= $signed(lo_reg));
        stat.prob_zero   = (prob_reg == 25'd0);
        stat.prob_full   = (prob_reg >= 25'(1 << PROB_BITS));
        stat.mul_done    = mul_busy_reg && (mul_cnt_reg == 2'd3);
        stat.div_done    = div_busy_reg && (div_cnt_reg == 5'd31);
        stat.word_ge_thr = (word_reg >= thr_reg);
        stat.out_free    = !out_valid_reg || m_tready;
        stat.cfg_known   = (cfg_index == 8'd0) || (cfg_index == 8'd1);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
endmodule
`default_nettype wire

// ===== rtl/core/pcg_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pcg_controller import pcg_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SEED  = 5'd1;
    localparam logic [4:0] ST_DRAW  = 5'd2;
    localparam logic [4:0] ST_DMUL  = 5'd3;
    localparam logic [4:0] ST_DUPD  = 5'd4;
    localparam logic [4:0] ST_AFTER = 5'd5;
    localparam logic [4:0] ST_MIX0  = 5'd6;
    localparam logic [4:0] ST_MIX1  = 5'd7;
    localparam logic [4:0] ST_MW1   = 5'd8;
    localparam logic [4:0] ST_MIX2  = 5'd9;
    localparam logic [4:0] ST_MW2   = 5'd10;
    localparam logic [4:0] ST_MIX3  = 5'd11;
    localparam logic [4:0] ST_DISP  = 5'd12;
    localparam logic [4:0] ST_THRW  = 5'd13;
    localparam logic [4:0] ST_THRS  = 5'd14;
    localparam logic [4:0] ST_DIVW  = 5'd15;
    localparam logic [4:0] ST_DCHK  = 5'd16;
    localparam logic [4:0] ST_OUT   = 5'd17;

    localparam logic [2:0] PH_SEED1  = 3'd0;
    localparam logic [2:0] PH_SEED2  = 3'd1;
    localparam logic [2:0] PH_W32    = 3'd2;
    localparam logic [2:0] PH_W64A   = 3'd3;
    localparam logic [2:0] PH_W64B   = 3'd4;
    localparam logic [2:0] PH_BELOW  = 3'd5;
    localparam logic [2:0] PH_FRAC   = 3'd6;
    localparam logic [2:0] PH_CHANCE = 3'd7;

    logic [4:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cmd.op       = OP_NONE;
        cmd.res_we   = 1'b0;
        cmd.res_sel  = RES_ZERO;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    if (stat.cfg_known) state_next = ST_SEED;
                end else if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_SEED: begin
                cmd.op     = OP_SEED_INIT;
                phase_next = PH_SEED1;
                state_next = ST_DRAW;
            end
            ST_DRAW: begin
                cmd.op     = OP_DRAW;
                state_next = ST_DMUL;
            end
            ST_DMUL: if (stat.mul_done) state_next = ST_DUPD;
            ST_DUPD: begin
                cmd.op     = OP_STATE_UPD;
                state_next = ST_AFTER;
            end
            ST_AFTER: begin
                case (phase_reg)
                    PH_SEED1: state_next = ST_MIX0;
                    PH_SEED2: state_next = ST_IDLE;
                    PH_W32: begin
                        cmd.res_we = 1'b1; cmd.res_sel = RES_WORD; state_next = ST_OUT;
                    end
                    PH_W64A: begin
                        cmd.res_we = 1'b1; cmd.res_sel = RES_HI;
                        phase_next = PH_W64B; state_next = ST_DRAW;
                    end
                    PH_W64B: begin
                        cmd.res_we = 1'b1; cmd.res_sel = RES_LO; state_next = ST_OUT;
                    end
                    PH_BELOW: begin
                        cmd.op = OP_DIV_WORD; state_next = ST_DIVW;
                    end
                    PH_FRAC: begin
                        cmd.res_we = 1'b1; cmd.res_sel = RES_FRAC; state_next = ST_OUT;
                    end
                    default: begin
                        cmd.res_we = 1'b1; cmd.res_sel = RES_CHANCE; state_next = ST_OUT;
                    end
                endcase
            end
            ST_MIX0: begin
                cmd.op     = OP_MIX_ADD;
                state_next = ST_MIX1;
            end
            ST_MIX1: begin
                cmd.op     = OP_MUL_X1;
                state_next = ST_MW1;
            end
            ST_MW1: if (stat.mul_done) state_next = ST_MIX2;
            ST_MIX2: begin
                cmd.op     = OP_X_PROD;
                state_next = ST_MW2;
                phase_next = PH_SEED1;
            end
            ST_MW2: begin
                cmd.op     = OP_MUL_X2;
                state_next = ST_MIX3;
            end
            ST_MIX3: begin
                if (stat.mul_done) begin
                    state_next = ST_THRS;
                    phase_next = PH_SEED2;
                end
            end
            ST_DISP: begin
                case (stat.command)
                    CMD_WORD32: begin phase_next = PH_W32;  state_next = ST_DRAW; end
                    CMD_WORD64: begin phase_next = PH_W64A; state_next = ST_DRAW; end
                    CMD_BELOW, CMD_RANGE: begin
                        if (stat.span_zero ||
                            (stat.command == CMD_RANGE && stat.range_empty)) begin
                            cmd.res_we = 1'b1; cmd.res_sel = RES_BASE; state_next = ST_OUT;
                        end else begin
                            cmd.op = OP_DIV_THR; phase_next = PH_BELOW; state_next = ST_THRW;
                        end
                    end
                    CMD_FRAC: begin phase_next = PH_FRAC; state_next = ST_DRAW; end
                    CMD_CHANCE: begin
                        if (stat.prob_zero) begin
                            cmd.res_we = 1'b1; cmd.res_sel = RES_ZERO; state_next = ST_OUT;
                        end else if (stat.prob_full) begin
                            cmd.res_we = 1'b1; cmd.res_sel = RES_ONE; state_next = ST_OUT;
                        end else begin
                            phase_next = PH_CHANCE; state_next = ST_DRAW;
                        end
                    end
                    default: begin
                        cmd.res_we = 1'b1; cmd.res_sel = RES_ZERO; state_next = ST_OUT;
                    end
                endcase
            end
            ST_THRW: if (stat.div_done) state_next = ST_THRS;
            ST_THRS: begin
                // shared tail: threshold capture, or the capture of the second mix product during seeding
                if (phase_reg == PH_SEED2) begin
                    cmd.op = OP_X_PROD;
                    state_next = ST_DCHK;
                end else begin
                    cmd.op     = OP_THR_SAVE;
                    phase_next = PH_BELOW;
                    state_next = ST_DRAW;
                end
            end
            ST_DIVW: if (stat.div_done) state_next = ST_DCHK;
            ST_DCHK: begin
                if (phase_reg == PH_SEED2) begin
                    cmd.op     = OP_ADD_MIX;
                    state_next = ST_DRAW;
                end else if (stat.word_ge_thr) begin
                    cmd.res_we = 1'b1; cmd.res_sel = RES_REM; state_next = ST_OUT;
                end else begin
                    state_next = ST_DRAW;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SEED;
            phase_reg <= PH_SEED1;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/pcg32_random_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// PCG32 XSH-RR draw source. One request in, one 64-bit value out. Each 32-bit
// word uses the shared 32x32 multiplier, which forms the 64-bit LCG product in
// four steps. Word, fraction and chance requests draw one word, a 64-bit word
// two; bounded and ranged draws use a restoring remainder unit once for the
// threshold and once per word drawn, and draw again for each rejected word.
// Requests that need no draw are answered without one. Seeding runs at reset
// and after a write to register 0 or 1; no request is taken while it runs.
module pcg32_random_generator import pcg_pkg::*; #(
    parameter int FRACTION_BITS = 24
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // [2:0] command, [34:3] bound, [66:35] range_low, [98:67] range_high,
    // [123:99] probability, [127:124] zero
    input  wire logic [127:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [63:0] value
    output logic [63:0]        m_tdata,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [63:0]   cfg_data
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    pcg_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pcg_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire

// ===== rtl/core/pcg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pcg_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [7:0]   cfg_index
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !cfg_ready)
        else $error("second request taken while one is in progress");

    a_reseed_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && (cfg_index == 8'd0 || cfg_index == 8'd1)
        |=> !s_tready)
        else $error("request taken during reseed");

    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("output or input live right after reset");
endmodule

bind pcg32_random_generator pcg_checker u_pcg_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);
`default_nettype wire

// ===== sim/pcg32_random_generator_test.sv =====
`timescale 1ns / 1ps
module pcg32_random_generator_test import pcg_pkg::*;;
    localparam int          FRAC_W      = 24;
    localparam int          STALL_LIMIT = 20000;
    localparam logic [2:0]  CMD_RSVD_A  = 3'd6;
    localparam logic [2:0]  CMD_RSVD_B  = 3'd7;
    localparam logic [7:0]  REG_SEED    = 8'd0;
    localparam logic [7:0]  REG_SEQ     = 8'd1;
    localparam logic [7:0]  REG_NONE    = 8'd5;
    localparam logic [24:0] PROB_ONE    = 25'h1000000;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] bound;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [24:0] prob;
        bit          known;
        logic [63:0] value;
    } draw_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    logic [63:0]  gen_state;
    logic [63:0]  stream_inc;
    logic [63:0]  seed_reg;
    logic [62:0]  seq_reg;
    logic [63:0]  draw_values_due[$];
    int           errors = 0;
    int           results_seen = 0;
    int           stall_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           rx_hold = 0;
    int           cfg_writes = 0;
    draw_row_t    dir_rows[$];

    always #10 aclk = ~aclk;

    pcg32_random_generator #(.FRACTION_BITS(FRAC_W)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic logic [63:0] splitmix(input logic [63:0] x);
        logic [63:0] z;
        z = x + MIX_GOLD;
        z = (z ^ (z >> 30)) * MIX_C1;
        z = (z ^ (z >> 27)) * MIX_C2;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [31:0] next_word();
        logic [63:0] old;
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] twice;
        old = gen_state;
        gen_state = old * PCG_MULT + stream_inc;
        xs = 32'(((old >> 18) ^ old) >> 27);
        rot = old[63:59];
        twice = {xs, xs} >> rot;
        return twice[31:0];
    endfunction

    function automatic void reseed_generator();
        gen_state = '0;
        stream_inc = {seq_reg, 1'b1};
        void'(next_word());
        gen_state = gen_state + splitmix(seed_reg);
        void'(next_word());
    endfunction

    function automatic logic [31:0] unbiased_below(input logic [31:0] bound);
        logic [31:0] thr;
        logic [31:0] r;
        if (bound == 0) return '0;
        thr = (32'd0 - bound) % bound;
        forever begin
            r = next_word();
            if (r >= thr) return r % bound;
        end
    endfunction

    function automatic logic [63:0] predict_draw(input logic [127:0] d);
        logic [2:0]  cmd;
        logic [31:0] bound, lo, hi, w;
        logic [24:0] prob;
        logic [63:0] v;
        cmd = d[2:0];
        bound = d[34:3];
        lo = d[66:35];
        hi = d[98:67];
        prob = d[123:99];
        v = '0;
        case (cmd)
            CMD_WORD32: v = {32'd0, next_word()};
            CMD_WORD64: begin
                v[63:32] = next_word();
                v[31:0] = next_word();
            end
            CMD_BELOW: v = {32'd0, unbiased_below(bound)};
            CMD_RANGE: begin
                if ($signed(hi) <= $signed(lo)) v = {32'd0, lo};
                else v = {32'd0, 32'(lo + unbiased_below(hi - lo + 32'd1))};
            end
            CMD_FRAC: begin
                w = next_word();
                v = {32'd0, w >> (32 - FRAC_W)};
            end
            CMD_CHANCE: begin
                if (prob == 0) v = 64'd0;
                else if (prob >= PROB_ONE) v = 64'd1;
                else begin
                    w = next_word();
                    v = ((w >> (32 - PROB_BITS)) < prob) ? 64'd1 : 64'd0;
                end
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [127:0] pack_req(input logic [2:0] cmd, input logic [31:0] bound,
                                              input logic [31:0] lo, input logic [31:0] hi,
                                              input logic [24:0] prob);
        return {4'd0, prob, hi, lo, bound, cmd};
    endfunction

    function automatic logic [127:0] random_req();
        logic [2:0]  cmd;
        logic [31:0] bound, lo, hi;
        logic [24:0] prob;
        int          pick;
        pick = $urandom_range(99);
        cmd = (pick < 4) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        case ($urandom_range(3))
            0: bound = $urandom_range(16);
            1: bound = 32'h8000_0000 + $urandom_range(8);
            default: bound = $urandom;
        endcase
        lo = $urandom;
        case ($urandom_range(3))
            0: hi = lo + $urandom_range(20) - 5;
            1: hi = lo ^ 32'h8000_0000;
            default: hi = $urandom;
        endcase
        case ($urandom_range(7))
            0: prob = '0;
            1: prob = PROB_ONE;
            2: prob = 25'($urandom_range(32'h1ff_ffff, 32'h100_0001));
            default: prob = 25'($urandom_range(32'hff_ffff, 1));
        endcase
        if ($urandom_range(9) == 0) prob = 25'($urandom);
        return pack_req(cmd, bound, lo, hi, prob);
    endfunction

    // monitor: predictions on accepted requests, checks on accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                if (cfg_index == REG_SEED) begin
                    seed_reg = cfg_data;
                    reseed_generator();
                end else if (cfg_index == REG_SEQ) begin
                    seq_reg = cfg_data[62:0];
                    reseed_generator();
                end
            end
            if (s_tvalid && s_tready)
                draw_values_due.push_back(predict_draw(s_tdata));
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (draw_values_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none, got %h", $time, m_tdata);
                end else begin
                    logic [63:0] want;
                    want = draw_values_due.pop_front();
                    if (want !== m_tdata) begin
                        errors++;
                        $display("%0t value mismatch: expected %h, got %h", $time, want, m_tdata);
                    end
                end
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t timeout, %0d results outstanding", $time, draw_values_due.size());
                $display("pcg32_random_generator_test: done, errors");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_req(input logic [127:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (draw_values_due.size() == 0);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
        drain();
        repeat (20) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            send_req(random_req());
        end
    endtask

    task automatic add_row(input logic [2:0] cmd, input logic [31:0] bound, input logic [31:0] lo,
                           input logic [31:0] hi, input logic [24:0] prob, input bit known,
                           input logic [63:0] value);
        draw_row_t r;
        r.cmd = cmd; r.bound = bound; r.lo = lo; r.hi = hi; r.prob = prob;
        r.known = known; r.value = value;
        dir_rows.push_back(r);
    endtask

    initial begin
        seed_reg = '0;
        seq_reg = '0;
        reseed_generator();

        add_row(CMD_WORD32, 0, 0, 0, 0, 0, 0);
        add_row(CMD_WORD32, 0, 0, 0, 0, 0, 0);
        add_row(CMD_WORD64, 0, 0, 0, 0, 0, 0);
        add_row(CMD_FRAC, 0, 0, 0, 0, 0, 0);
        add_row(CMD_CHANCE, 0, 0, 0, 25'h80_0000, 0, 0);
        add_row(CMD_CHANCE, 0, 0, 0, 25'd1, 0, 0);
        add_row(CMD_CHANCE, 0, 0, 0, 25'hff_ffff, 0, 0);
        add_row(CMD_CHANCE, 0, 0, 0, 25'd0, 1, 64'd0);
        add_row(CMD_CHANCE, 0, 0, 0, PROB_ONE, 1, 64'd1);
        add_row(CMD_CHANCE, 0, 0, 0, 25'h1ff_ffff, 1, 64'd1);
        add_row(CMD_BELOW, 32'd0, 0, 0, 0, 1, 64'd0);
        add_row(CMD_BELOW, 32'd1, 0, 0, 0, 0, 0);
        add_row(CMD_BELOW, 32'hffff_ffff, 0, 0, 0, 0, 0);
        add_row(CMD_BELOW, 32'h8000_0001, 0, 0, 0, 0, 0);
        add_row(CMD_RANGE, 0, 32'd5, 32'd5, 0, 1, 64'd5);
        add_row(CMD_RANGE, 0, 32'd7, -32'sd3, 0, 1, 64'd7);
        add_row(CMD_RANGE, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 1, 64'h8000_0000);
        add_row(CMD_RANGE, 0, 32'hffff_ffff, 32'd0, 0, 0, 0);
        add_row(CMD_RANGE, 0, 32'h8000_0000, 32'h8000_0001, 0, 0, 0);
        add_row(CMD_RANGE, 0, 32'd0, 32'h7fff_ffff, 0, 0, 0);
        add_row(CMD_RSVD_A, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 25'h1ff_ffff, 1, 64'd0);
        add_row(CMD_RSVD_B, 0, 0, 0, 0, 1, 64'd0);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 65;
        foreach (dir_rows[i]) begin
            logic [127:0] d;
            d = pack_req(dir_rows[i].cmd, dir_rows[i].bound, dir_rows[i].lo,
                         dir_rows[i].hi, dir_rows[i].prob);
            send_req(d);
            // fixed answers are checked against the queued prediction
            if (dir_rows[i].known && draw_values_due[$] !== dir_rows[i].value) begin
                errors++;
                $display("%0t fixed row %0d: expected %h, got %h", $time, i,
                         dir_rows[i].value, draw_values_due[$]);
            end
        end

        write_reg(REG_SEED, 64'hffff_ffff_ffff_ffff);
        random_phase(400, 16, 65);

        write_reg(REG_SEED, {$urandom, $urandom});
        write_reg(REG_SEQ, 64'h7fff_ffff_ffff_ffff);
        rx_hold = 400;
        random_phase(400, 65, 16);

        write_reg(REG_NONE, {$urandom, $urandom});
        write_reg(REG_SEED, 64'd0);
        write_reg(REG_SEQ, {$urandom, $urandom});
        random_phase(400, 0, 0);

        drain();
        repeat (50) @(posedge aclk);
        $display("covered %0d results, %0d register writes, three idling mixes", results_seen,
                 cfg_writes);
        $display("all six draw kinds, reserved codes, empty and full ranges, chance limits");
        if (errors == 0 && draw_values_due.size() == 0) begin
            $display("pcg32_random_generator_test: done, clean");
        end else begin
            $display("pcg32_random_generator_test: done, errors");
        end
        $finish;
    end
endmodule
